@@ src/ketq_pkg.sv @@
`timescale 1ns / 1ps
// Shared codes and types for the keyed event time queue.
// No dependencies; imported by ketq_cell and the top level.
package ketq_pkg;

  // operation codes carried by an input request
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // status codes carried by a result
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_INFINITE = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // what a cell loads at the next edge
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_NEXT,
    CELL_PREV,
    CELL_NEW
  } cell_mode_t;

endpackage

@@ src/ketq_scan.sv @@
`timescale 1ns / 1ps
// Inclusive prefix OR over a row of flags, log-depth.
// Depends on nothing but its width parameter.
module ketq_scan #(
  parameter int WIDTH = 64
) (
  input  logic [WIDTH-1:0] flags,
  output logic [WIDTH-1:0] flags_or
);

  localparam int LEVELS = $clog2(WIDTH);

  logic [LEVELS:0][WIDTH-1:0] lvl;

  // each level folds in flags from 2**l places further down
  always_comb begin
    lvl[0] = flags;
    for (int l = 0; l < LEVELS; l++) begin
      for (int i = 0; i < WIDTH; i++) begin
        if (i >= (1 << l)) begin
          lvl[l+1][i] = lvl[l][i] | lvl[l][i-(1<<l)];
        end else begin
          lvl[l+1][i] = lvl[l][i];
        end
      end
    end
  end

  assign flags_or = lvl[LEVELS];

endmodule

@@ src/ketq_cell.sv @@
`timescale 1ns / 1ps
// One slot of the sorted queue: holds one event, compares it with the
// broadcast key and time, and loads from a neighbour or the new event.
// Depends on ketq_pkg.
module ketq_cell
  import ketq_pkg::*;
#(
  parameter int INDEX_BITS = 16,
  parameter int TIME_BITS  = 32
) (
  input  logic                  clk,
  input  cell_mode_t            mode,
  input  logic                  occupied,
  input  logic [INDEX_BITS-1:0] key_index,
  input  logic [TIME_BITS-1:0]  key_time,
  input  logic [INDEX_BITS-1:0] new_index,
  input  logic [TIME_BITS-1:0]  new_time,
  input  logic [INDEX_BITS-1:0] prev_index,
  input  logic [TIME_BITS-1:0]  prev_time,
  input  logic [INDEX_BITS-1:0] next_index,
  input  logic [TIME_BITS-1:0]  next_time,
  output logic [INDEX_BITS-1:0] cell_index,
  output logic [TIME_BITS-1:0]  cell_time,
  output logic                  match,
  output logic                  time_le
);

  logic [INDEX_BITS-1:0] index_r;
  logic [TIME_BITS-1:0]  time_r;

  always_ff @(posedge clk) begin
    case (mode)
      CELL_NEXT: begin
        index_r <= next_index;
        time_r  <= next_time;
      end
      CELL_PREV: begin
        index_r <= prev_index;
        time_r  <= prev_time;
      end
      CELL_NEW: begin
        index_r <= new_index;
        time_r  <= new_time;
      end
      default: begin
        index_r <= index_r;
        time_r  <= time_r;
      end
    endcase
  end

  assign cell_index = index_r;
  assign cell_time  = time_r;
  assign match      = occupied && (index_r == key_index);
  assign time_le    = occupied && (time_r <= key_time);

endmodule

@@ src/keyed_event_time_queue_unit.sv @@
`timescale 1ns / 1ps
// Top level of the keyed event time queue: control sequencer, slot count,
// result register and the row of ketq_cell slots. Depends on ketq_pkg,
// ketq_cell and ketq_scan.
//
//  channel | ports          | tdata fields, lowest bit first
//  --------+----------------+------------------------------------------------
//  input   | in_t*          | operation, neuron_index, spike_time, time_finite
//  result  | out_t*         | status, popped_valid, popped_index, popped_time,
//          |                | pending_count, has_pending
//
// Steps: a pop, clear, spare code or rejected insert passes from the accepting
// state to the execute step, which writes the result register; a finite
// insert adds a placement step (key match on acceptance, removal shift,
// placement shift), and the placement step writes its result.
// One request is in flight at a time; a new one is accepted as soon as the
// previous one has moved into the result register, even while it waits.
// A stalled result register holds the sequencer in its last step.
// Reset clears the slot count and the sequencer; slot contents are kept.
module keyed_event_time_queue_unit
  import ketq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 64,
  parameter int INDEX_BITS  = 16,
  parameter int TIME_BITS   = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  // operation, neuron_index, spike_time, time_finite
  input  logic [((2 + INDEX_BITS + TIME_BITS + 1 + 7) / 8) * 8 - 1:0] in_tdata,
  output logic           out_tvalid,
  input  logic           out_tready,
  // status, popped_valid, popped_index, popped_time, pending_count, has_pending
  output logic [((3 + INDEX_BITS + TIME_BITS + $clog2(QUEUE_DEPTH + 1) + 1 + 7) / 8) * 8
                - 1:0] out_tdata
);

  localparam int CW       = $clog2(QUEUE_DEPTH + 1);
  localparam int OUT_BITS = 2 + 1 + INDEX_BITS + TIME_BITS + CW + 1;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;
  localparam int IDX_LO   = 2;
  localparam int TIME_LO  = IDX_LO + INDEX_BITS;
  localparam int FIN_BIT  = TIME_LO + TIME_BITS;
  localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_PLACE
  } state_t;

  // unpack the request
  logic [1:0]            in_op;
  logic [INDEX_BITS-1:0] in_index;
  logic [TIME_BITS-1:0]  in_time;
  logic                  in_fin;

  assign in_op    = in_tdata[1:0];
  assign in_index = in_tdata[IDX_LO +: INDEX_BITS];
  assign in_time  = in_tdata[TIME_LO +: TIME_BITS];
  assign in_fin   = in_tdata[FIN_BIT];

  state_t                 state_r, state_nxt;
  logic [1:0]             op_r, op_nxt;
  logic [INDEX_BITS-1:0]  index_r, index_nxt;
  logic [TIME_BITS-1:0]   time_r, time_nxt;
  logic                   fin_r, fin_nxt;
  logic [QUEUE_DEPTH-1:0] match_r, match_nxt;
  logic [CW-1:0]          count_r, count_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [1:0]            out_status_r, out_status_nxt;
  logic                  out_pv_r, out_pv_nxt;
  logic [INDEX_BITS-1:0] out_pi_r, out_pi_nxt;
  logic [TIME_BITS-1:0]  out_pt_r, out_pt_nxt;
  logic [CW-1:0]         out_cnt_r, out_cnt_nxt;

  // cell row wiring
  logic [INDEX_BITS-1:0] c_index [QUEUE_DEPTH];
  logic [TIME_BITS-1:0]  c_time  [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] c_match;
  logic [QUEUE_DEPTH-1:0] c_le;
  logic [QUEUE_DEPTH-1:0] removed_at_or_below;
  cell_mode_t            c_mode [QUEUE_DEPTH];

  logic slot_free;
  logic do_remove;
  logic do_pop;
  logic do_place;

  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);

  // removal shift: the matched slot and all above it take their upper neighbour
  ketq_scan #(
    .WIDTH (QUEUE_DEPTH)
  ) u_scan (
    .flags    (match_r),
    .flags_or (removed_at_or_below)
  );

  assign do_remove = (state_r == S_EXEC) && (op_r == OP_INSERT) && fin_r;
  assign do_pop    = (state_r == S_EXEC) && (op_r == OP_POP) && (count_r != '0)
                     && slot_free;
  assign do_place  = (state_r == S_PLACE) && slot_free && (count_r != FULL_COUNT);

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [INDEX_BITS-1:0] prev_index, next_index;
    logic [TIME_BITS-1:0]  prev_time, next_time;
    logic                  prev_le;
    logic                  occupied;

    if (i == 0) begin : g_first
      assign prev_index = index_r;
      assign prev_time  = time_r;
      assign prev_le    = 1'b1;
    end else begin : g_inner_prev
      assign prev_index = c_index[i-1];
      assign prev_time  = c_time[i-1];
      assign prev_le    = c_le[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign next_index = index_r;
      assign next_time  = time_r;
    end else begin : g_inner_next
      assign next_index = c_index[i+1];
      assign next_time  = c_time[i+1];
    end

    assign occupied = (CW'(i) < count_r);

    // removal and pop shift slots down from their upper neighbour; placement:
    // later events step up one slot, the first later slot takes the new event
    always_comb begin
      c_mode[i] = CELL_HOLD;
      if (do_remove && removed_at_or_below[i]) begin
        c_mode[i] = CELL_NEXT;
      end else if (do_pop) begin
        c_mode[i] = CELL_NEXT;
      end else if (do_place && !c_le[i]) begin
        c_mode[i] = prev_le ? CELL_NEW : CELL_PREV;
      end
    end

    ketq_cell #(
      .INDEX_BITS (INDEX_BITS),
      .TIME_BITS  (TIME_BITS)
    ) u_cell (
      .clk        (clk),
      .mode       (c_mode[i]),
      .occupied   (occupied),
      .key_index  (in_index),
      .key_time   (time_r),
      .new_index  (index_r),
      .new_time   (time_r),
      .prev_index (prev_index),
      .prev_time  (prev_time),
      .next_index (next_index),
      .next_time  (next_time),
      .cell_index (c_index[i]),
      .cell_time  (c_time[i]),
      .match      (c_match[i]),
      .time_le    (c_le[i])
    );
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    index_nxt      = index_r;
    time_nxt       = time_r;
    fin_nxt        = fin_r;
    match_nxt      = match_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_pv_nxt     = out_pv_r;
    out_pi_nxt     = out_pi_r;
    out_pt_nxt     = out_pt_r;
    out_cnt_nxt    = out_cnt_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          // latch the request and the key match against the stored events
          op_nxt    = in_op;
          index_nxt = in_index;
          time_nxt  = in_time;
          fin_nxt   = in_fin;
          match_nxt = c_match;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (op_r == OP_INSERT && fin_r) begin
          // drop any stored event of the same neuron, then place
          count_nxt = count_r - CW'(|match_r);
          state_nxt = S_PLACE;
        end else if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_pv_nxt     = 1'b0;
          out_pi_nxt     = '0;
          out_pt_nxt     = '0;
          unique case (op_r)
            OP_INSERT: begin
              out_status_nxt = ST_INFINITE;
            end
            OP_POP: begin
              if (count_r == '0) begin
                out_status_nxt = ST_EMPTY;
              end else begin
                out_pv_nxt = 1'b1;
                out_pi_nxt = c_index[0];
                out_pt_nxt = c_time[0];
                count_nxt  = count_r - CW'(1);
              end
            end
            OP_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
              out_status_nxt = ST_OK;
            end
          endcase
          out_cnt_nxt = (op_r == OP_CLEAR) ? '0 :
                        (out_pv_nxt ? count_r - CW'(1) : count_r);
          state_nxt   = S_IDLE;
        end
      end
      S_PLACE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_pv_nxt    = 1'b0;
          out_pi_nxt    = '0;
          out_pt_nxt    = '0;
          if (count_r == FULL_COUNT) begin
            out_status_nxt = ST_FULL;
            out_cnt_nxt    = count_r;
          end else begin
            out_status_nxt = ST_OK;
            count_nxt      = count_r + CW'(1);
            out_cnt_nxt    = count_r + CW'(1);
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    index_r      <= index_nxt;
    time_r       <= time_nxt;
    fin_r        <= fin_nxt;
    match_r      <= match_nxt;
    out_status_r <= out_status_nxt;
    out_pv_r     <= out_pv_nxt;
    out_pi_r     <= out_pi_nxt;
    out_pt_r     <= out_pt_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({(out_cnt_r != '0), out_cnt_r, out_pt_r, out_pi_r,
                              out_pv_r, out_status_r});

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_COUNT)
    else $error("slot count above queue depth");

  a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |-> $onehot0(match_r))
    else $error("more than one stored event for one neuron");

  a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_pv_r) |-> (out_status_r == ST_OK))
    else $error("popped event reported with a failure status");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    do_pop |=> (count_r == $past(count_r) - CW'(1)))
    else $error("pop did not shrink the queue by one");

  a_full_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PLACE && slot_free && count_r == FULL_COUNT)
      |=> (count_r == FULL_COUNT))
    else $error("dropped insert changed the slot count");

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking bench for keyed_event_time_queue_unit: streams requests with bursty
// input and a stalling receiver, and predicts every result from a local model.
// Depends on ketq_pkg and the block's RTL.
module testbench;
  import ketq_pkg::*;

  localparam int QUEUE_SLOTS = 64;
  localparam int RANDOM_ITEMS = 600;
  // the one operation code the block leaves unused
  localparam logic [1:0] OP_SPARE = 2'd3;

  typedef struct {
    logic [15:0] neuron;
    logic [31:0] stamp;
  } spike_event_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        popped_valid;
    logic [15:0] popped_index;
    logic [31:0] popped_time;
    logic [6:0]  pending_count;
    logic        has_pending;
  } outcome_t;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_SPARSE,
    RX_BLOCKED
  } rx_mode_t;

  // Holds the predicted queue contents and the results still owed by the block.
  class event_order_board;
    spike_event_t held[$];
    outcome_t     due[$];
    int mismatches = 0;
    int n_insert = 0, n_rejected = 0, n_dropped = 0;
    int n_pop = 0, n_pop_empty = 0, n_clear = 0, n_spare = 0, deepest = 0;

    // Apply one accepted request to the model and queue its result.
    function void note_request(logic [1:0] op, logic [15:0] neuron, logic [31:0] stamp,
                               logic finite);
      outcome_t     want;
      spike_event_t kept[$];
      spike_event_t fresh;
      int           slot;
      want = '0;
      case (op)
        OP_INSERT: begin
          n_insert++;
          if (!finite) begin
            // leave the queue untouched, even an event of the same neuron
            want.status = ST_INFINITE;
            n_rejected++;
          end else begin
            foreach (held[i]) if (held[i].neuron != neuron) kept.insert(kept.size(), held[i]);
            held.delete();
            if (kept.size() >= QUEUE_SLOTS) begin
              // the removal stands even though the new event is dropped
              want.status = ST_FULL;
              n_dropped++;
              held = kept;
            end else begin
              fresh.neuron = neuron;
              fresh.stamp  = stamp;
              slot = 0;
              // place after every event of equal or smaller time
              while (slot < kept.size() && kept[slot].stamp <= stamp) slot++;
              foreach (kept[i]) begin
                if (i == slot) held.insert(held.size(), fresh);
                held.insert(held.size(), kept[i]);
              end
              if (slot == kept.size()) held.insert(held.size(), fresh);
            end
          end
        end
        OP_POP: begin
          n_pop++;
          if (held.size() == 0) begin
            want.status = ST_EMPTY;
            n_pop_empty++;
          end else begin
            fresh = held[0];
            held.delete(0);
            want.popped_valid = 1'b1;
            want.popped_index = fresh.neuron;
            want.popped_time  = fresh.stamp;
          end
        end
        OP_CLEAR: begin
          n_clear++;
          held.delete();
        end
        default: n_spare++;
      endcase
      want.pending_count = 7'(held.size());
      want.has_pending   = (held.size() != 0);
      if (held.size() > deepest) deepest = held.size();
      due.insert(due.size(), want);
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        mismatches++;
      end
    endfunction

    // Match one accepted result against the oldest outstanding prediction.
    function void check_result(logic [63:0] word);
      outcome_t want;
      if (due.size() == 0) begin
        $error("result %h arrived with no request outstanding", word);
        mismatches++;
        return;
      end
      want = due[0];
      due.delete(0);
      compare("status",        32'(want.status),        32'(word[1:0]));
      compare("popped_valid",  32'(want.popped_valid),  32'(word[2]));
      compare("popped_index",  32'(want.popped_index),  32'(word[18:3]));
      compare("popped_time",   want.popped_time,        word[50:19]);
      compare("pending_count", 32'(want.pending_count), 32'(word[57:51]));
      compare("has_pending",   32'(want.has_pending),   32'(word[58]));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // operation, neuron_index, spike_time, time_finite, zero padding
  logic [55:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // status, popped_valid, popped_index, popped_time, pending_count, has_pending, padding
  logic [63:0] out_tdata;

  event_order_board sb;
  int       items_sent = 0;
  int       burst_left = 0;
  bit       gappy = 1'b0;
  rx_mode_t rx_mode = RX_FREE;
  int       rx_cycle = 0;
  int       stall_left = 0;

  keyed_event_time_queue_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #10 clk = ~clk;

  // Receiver: repeatedly picks a random stall pattern among always ready,
  // sparse random ready and long blocked stretches.
  always @(negedge clk) begin
    if (rx_cycle % 150 == 0) rx_mode = rx_mode_t'($urandom_range(0, 2));
    rx_cycle++;
    case (rx_mode)
      RX_FREE:   out_tready <= 1'b1;
      RX_SPARSE: out_tready <= ($urandom_range(0, 9) < 7);
      default: begin
        if (stall_left != 0) begin
          stall_left--;
          out_tready <= 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
          stall_left = $urandom_range(1, 12);
          out_tready <= 1'b0;
        end else begin
          out_tready <= 1'b1;
        end
      end
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Pick a time: often random, often coarse whole values so that ties occur,
  // sometimes the extremes or a small value.
  function automatic logic [31:0] pick_time();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return {16'($urandom_range(0, 7)), 16'h0000};
      7:          return 32'h0000_0000;
      8:          return 32'hFFFF_FFFF;
      default:    return $urandom_range(0, 3);
    endcase
  endfunction

  // Drive one request from a falling edge and hold it until accepted. Bursts of
  // random length have gaps between them, drawn on or off every hundred requests.
  task automatic send_request(input logic [1:0] op, input logic [15:0] neuron,
                              input logic [31:0] stamp, input logic finite);
    int gap;
    if (items_sent % 100 == 0) gappy = ($urandom_range(0, 1) == 1);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = gappy ? $urandom_range(1, 8) : 0;
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        in_tdata  <= 56'({$urandom, $urandom});
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, finite, stamp, neuron, op};
    do @(posedge clk); while (!in_tready);
    sb.note_request(op, neuron, stamp, finite);
    items_sent++;
    @(negedge clk);
  endtask

  // Fill with distinct neurons past capacity, hammer the full queue with
  // replacements and newcomers, then drain with the odd insert mixed in.
  task automatic fill_and_drain();
    logic [15:0] base;
    int          extra;
    base  = 16'($urandom);
    extra = $urandom_range(1, 6);
    for (int k = 0; k < QUEUE_SLOTS + extra; k++)
      send_request(OP_INSERT, 16'(base + k), pick_time(), 1'b1);
    repeat (12)
      send_request(OP_INSERT, 16'(base + $urandom_range(0, QUEUE_SLOTS + 10)), pick_time(),
                   $urandom_range(0, 7) != 0);
    repeat ($urandom_range(20, 70)) begin
      if ($urandom_range(0, 3) == 0)
        send_request(OP_INSERT, 16'(base + $urandom_range(0, QUEUE_SLOTS + 10)),
                     pick_time(), 1'b1);
      else
        send_request(OP_POP, 16'($urandom), $urandom, 1'($urandom_range(0, 1)));
    end
  endtask

  // Mixed traffic over a small pool of neurons, so replacements are common.
  task automatic churn();
    logic [15:0] base;
    int          pool;
    int          pick;
    base = 16'($urandom);
    pool = $urandom_range(1, 40);
    repeat ($urandom_range(20, 60)) begin
      pick = $urandom_range(0, 99);
      if (pick < 55)
        send_request(OP_INSERT, 16'(base + $urandom_range(0, pool - 1)), pick_time(), 1'b1);
      else if (pick < 85)
        send_request(OP_POP, 16'($urandom), $urandom, 1'($urandom_range(0, 1)));
      else if (pick < 92)
        send_request(OP_INSERT, 16'(base + $urandom_range(0, pool - 1)), pick_time(), 1'b0);
      else if (pick < 95)
        send_request(OP_CLEAR, 16'($urandom), $urandom, 1'($urandom_range(0, 1)));
      else
        send_request(OP_SPARE, 16'($urandom), $urandom, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    int guard;
    int pick;
    sb = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty pop, extremes, ties, replacement, rejects, spare code, clear
    send_request(OP_POP, 16'h0000, 32'h0000_0000, 1'b0);
    send_request(OP_INSERT, 16'h0000, 32'h0005_0000, 1'b1);
    send_request(OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    send_request(OP_INSERT, 16'h1234, 32'h0005_0000, 1'b1);
    send_request(OP_INSERT, 16'h00AA, 32'h0000_0000, 1'b1);
    send_request(OP_INSERT, 16'h0000, 32'h0001_8000, 1'b1);
    send_request(OP_INSERT, 16'hFFFF, 32'h0000_0000, 1'b0);
    send_request(OP_INSERT, 16'h5555, 32'hFFFF_FFFF, 1'b0);
    send_request(OP_SPARE, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    send_request(OP_POP, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    send_request(OP_POP, 16'h0000, 32'h0000_0000, 1'b0);
    send_request(OP_INSERT, 16'h8001, 32'h0005_0000, 1'b1);
    send_request(OP_POP, 16'h0000, 32'h0000_0000, 1'b0);
    send_request(OP_POP, 16'h0000, 32'h0000_0000, 1'b0);
    send_request(OP_POP, 16'h0000, 32'h0000_0000, 1'b0);
    send_request(OP_POP, 16'h0000, 32'h0000_0000, 1'b0);
    send_request(OP_CLEAR, 16'h0000, 32'h0000_0000, 1'b0);
    send_request(OP_INSERT, 16'h0042, 32'h7FFF_FFFF, 1'b1);
    send_request(OP_INSERT, 16'h0043, 32'h8000_0000, 1'b1);
    send_request(OP_CLEAR, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    send_request(OP_POP, 16'h0000, 32'h0000_0000, 1'b0);

    // random: open with a full-queue pass, then mix phases
    fill_and_drain();
    while (items_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
        fill_and_drain();
      end else if (pick < 7) begin
        churn();
      end else if (pick < 9) begin
        repeat (sb.held.size() + $urandom_range(1, 3))
          send_request(OP_POP, 16'($urandom), $urandom, 1'($urandom_range(0, 1)));
      end else begin
        send_request(OP_CLEAR, 16'($urandom), $urandom, 1'($urandom_range(0, 1)));
        send_request(OP_POP, 16'($urandom), $urandom, 1'($urandom_range(0, 1)));
      end
    end
    in_tvalid <= 1'b0;

    // drain outstanding results, then watch for stray output
    guard = 0;
    while (sb.due.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
    if (sb.due.size() != 0) begin
      $error("%0d results never arrived", sb.due.size());
      sb.mismatches++;
    end

    $display("Covered %0d requests: %0d inserts (%0d non-finite, %0d dropped on full),",
             items_sent, sb.n_insert, sb.n_rejected, sb.n_dropped);
    $display("%0d pops (%0d on empty), %0d clears, %0d spare codes; deepest queue %0d",
             sb.n_pop, sb.n_pop_empty, sb.n_clear, sb.n_spare, sb.deepest);
    if (sb.mismatches == 0) begin
      $display("[keyed_event_time_queue_unit] OK");
    end else begin
      $display("[keyed_event_time_queue_unit] ERROR");
    end
    $finish;
  end

  // watchdog: far beyond the slowest correct run
  initial begin
    #4000000;
    $display("[keyed_event_time_queue_unit] ERROR");
    $finish;
  end

endmodule
